// ===== rtl/unordered_set_table_core_macros.svh =====
// Assertion macros used by the checker file of the set table.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef UNORDERED_SET_TABLE_CORE_MACROS_SVH
`define UNORDERED_SET_TABLE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define UST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ust_pkg.sv =====
// Shared types and constants of the unordered set table.
// No dependencies; imported by every module of the block but ust_ram.
package ust_pkg;

    localparam int REQ_W       = 2;
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    typedef struct packed {
        logic               found;
        logic               changed;
        logic               full_refused;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

// ===== rtl/ust_ram.sv =====
// Key storage: single-port-write, single-port-read RAM with registered read data.
// Depends on nothing but its parameters.
module ust_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ust_ctrl.sv =====
// Request sequencer: scans the key RAM, then appends, moves or leaves entries.
// Depends on ust_pkg; drives the ports of ust_ram.
module ust_ctrl
    import ust_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KW       = 32,
    parameter int AW       = 6,
    parameter int OCC_W    = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_mem_rd_en,
    output logic [AW-1:0]    o_mem_rd_addr,
    input  logic [KW-1:0]    i_mem_rd_data,
    output logic             o_mem_wr_en,
    output logic [AW-1:0]    o_mem_wr_addr,
    output logic [KW-1:0]    o_mem_wr_data,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    localparam int EXT_W = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_MOVE,
        S_DONE
    } t_state;

    t_state             r_state,   n_state;
    logic [OCC_W-1:0]   r_occ,     n_occ;
    logic [KW-1:0]      r_key,     n_key;
    logic [REQ_W-1:0]   r_type,    n_type;
    logic [OCC_W-1:0]   r_issue,   n_issue;
    logic [OCC_W-1:0]   r_chk,     n_chk;
    logic               r_chk_vld, n_chk_vld;
    logic [AW-1:0]      r_slot,    n_slot;
    logic               r_found,   n_found;
    logic               r_changed, n_changed;
    logic               r_refused, n_refused;

    logic [OCC_W-1:0]   occ_last;
    logic [EXT_W-1:0]   occ_ext;

    assign occ_last = r_occ - OCC_W'(1);
    assign occ_ext  = EXT_W'(r_occ);

    always_comb begin
        n_state       = r_state;
        n_occ         = r_occ;
        n_key         = r_key;
        n_type        = r_type;
        n_issue       = r_issue;
        n_chk         = r_chk;
        n_chk_vld     = 1'b0;
        n_slot        = r_slot;
        n_found       = r_found;
        n_changed     = r_changed;
        n_refused     = r_refused;
        o_req_ready   = 1'b0;
        o_res_valid   = 1'b0;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_issue[AW-1:0];
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_occ[AW-1:0];
        o_mem_wr_data = r_key;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_key     = i_key[KW-1:0];
                    n_type    = i_req_type;
                    n_issue   = '0;
                    n_found   = 1'b0;
                    n_changed = 1'b0;
                    n_refused = 1'b0;
                    n_state   = (r_occ == '0) ? S_ACT : S_SCAN;
                end
            end
            S_SCAN: begin
                // reads are pipelined: compare the entry issued last cycle
                if (r_issue < r_occ) begin
                    o_mem_rd_en = 1'b1;
                    n_issue     = r_issue + OCC_W'(1);
                end
                n_chk_vld = o_mem_rd_en;
                n_chk     = r_issue;
                if (r_chk_vld) begin
                    if (i_mem_rd_data == r_key) begin
                        n_found   = 1'b1;
                        n_slot    = r_chk[AW-1:0];
                        n_chk_vld = 1'b0;
                        n_state   = S_ACT;
                    end else if (r_chk == occ_last) begin
                        n_chk_vld = 1'b0;
                        n_state   = S_ACT;
                    end
                end
            end
            S_ACT: begin
                n_state = S_DONE;
                if (r_type == REQ_INSERT && !r_found) begin
                    if (r_occ < OCC_W'(CAPACITY)) begin
                        o_mem_wr_en = 1'b1;
                        n_occ       = r_occ + OCC_W'(1);
                        n_changed   = 1'b1;
                    end else begin
                        n_refused = 1'b1;
                    end
                end else if (r_type == REQ_DELETE && r_found) begin
                    // fetch the last entry to fill the hole
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = occ_last[AW-1:0];
                    n_changed     = 1'b1;
                    n_state       = S_MOVE;
                end
            end
            S_MOVE: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_slot;
                o_mem_wr_data = i_mem_rd_data;
                n_occ         = occ_last;
                n_state       = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_chk_vld <= n_chk_vld;
        end
        r_key     <= n_key;
        r_type    <= n_type;
        r_issue   <= n_issue;
        r_chk     <= n_chk;
        r_slot    <= n_slot;
        r_found   <= n_found;
        r_changed <= n_changed;
        r_refused <= n_refused;
    end

    assign o_res.found        = r_found;
    assign o_res.changed      = r_changed;
    assign o_res.full_refused = r_refused;
    assign o_res.count        = occ_ext[COUNT_W-1:0];

endmodule

// ===== rtl/ust_out.sv =====
// Output register stage: holds one result while the sequencer moves on.
// Depends on ust_pkg for the result struct and packing widths.
module ust_out
    import ust_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_res_valid,
    output logic                   o_res_ready,
    input  t_result                i_res,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata
);

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {(OUT_TDATA_W - COUNT_W - 3)'(0), r_res.count,
                       r_res.full_refused, r_res.changed, r_res.found};

endmodule

// ===== rtl/unordered_set_table_core.sv =====
// Top level of the unordered set table: request stream in, result stream out.
// Depends on ust_pkg, ust_ram, ust_ctrl and ust_out.
//
// Usage:
//   s_axis carries one request per transaction: insert, delete or lookup of a key.
//   m_axis returns exactly one result per request, in request order.
//   Keys sit unordered in a CAPACITY-deep RAM; occupancy is held in a register.
//   Each request scans the occupied entries with one RAM read per cycle,
//   stopping at the first match. A request passes through accept, scan,
//   update, delete move (deletes only) and result hand-off to m_axis_tvalid;
//   a hit ends the scan early. Requests are taken one at a time: a new one
//   is accepted only after the last result has gone to the output register.
//   The scan walks the single RAM read port.
//   A delete copies the last entry into the freed slot in an extra move state.
//   Reset (i_rst_n low, synchronous) empties the table at once; RAM contents
//   are not cleared, since only entries below the occupancy are ever read.
//   If m_axis_tready is low, the result waits in the output register and one
//   further request is still taken and processed; it then holds until the
//   output register frees up.
module unordered_set_table_core
    import ust_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // req_type[1:0], key[33:2]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // found, changed, full_refused, count[9:3]
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [KW-1:0] mem_rd_data;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [KW-1:0] mem_wr_data;
    logic          res_valid;
    logic          res_ready;
    t_result       res;

    ust_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (KW),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    ust_ctrl #(
        .CAPACITY (CAPACITY),
        .KW       (KW),
        .AW       (AW),
        .OCC_W    (OCC_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_req_type    (s_axis_tdata[REQ_W-1:0]),
        .i_key         (s_axis_tdata[REQ_W+KEY_W-1:REQ_W]),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    ust_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

// ===== rtl/ust_checker.sv =====
// Port-level checker for the unordered set table, bound to the top level.
// Depends on ust_pkg and unordered_set_table_core_macros.svh.
`include "unordered_set_table_core_macros.svh"

module ust_checker
    import ust_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [COUNT_W-1:0] count;
    logic               found;
    logic               changed;
    logic               refused;
    logic               in_hs;
    logic               out_stall;
    logic               count_ok;
    logic               at_cap;

    assign found   = m_axis_tdata[0];
    assign changed = m_axis_tdata[1];
    assign refused = m_axis_tdata[2];
    assign count   = m_axis_tdata[COUNT_W+2:3];

    assign in_hs     = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    // count is 7 bits wide, so the bound only holds for small tables
    assign count_ok  = (CAPACITY > 127) || (count <= CAPACITY);
    assign at_cap    = (CAPACITY > 127) || (count == CAPACITY);

    // one request in flight: no new transaction the cycle after one is taken
    `UST_ASSERT_NEXT(a_one_in_flight, in_hs, !s_axis_tready, "request taken while busy")
    `UST_ASSERT_NOW(a_count_bound, m_axis_tvalid, count_ok, "count above capacity")
    `UST_ASSERT_NOW(a_refuse_excl, m_axis_tvalid && refused, !found && !changed, "bad refusal")
    `UST_ASSERT_NOW(a_refuse_full, m_axis_tvalid && refused, at_cap, "refusal below capacity")
    `UST_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result changed")

endmodule

bind unordered_set_table_core ust_checker #(.CAPACITY(CAPACITY)) u_ust_checker (.*);
